// ===== rtl/flp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flp_pkg: shared types and constants of the first-order low-pass
// Widths, op and register codes, and the request/response of the shared
// shift-subtract divider.
// ----------------------------------------------------------------------------
package flp_pkg;

	localparam int DATA_W    = 32;
	localparam int ALPHA_W   = 16;
	localparam int WRAP_W    = 31;
	localparam int CFG_IDX_W = 2;
	localparam int DIFF_W    = DATA_W + 1;
	localparam int VAL_W     = DATA_W + 3;
	localparam int MUL_W     = DATA_W + 2;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int DIV_W     = 64;
	localparam int STEP_W    = 6;
	localparam int QUO_W     = ALPHA_W;

	localparam int ALPHA_STEPS = QUO_W;
	localparam int M_ONE_BIT   = 46;

	typedef logic [1:0]               op_t;
	typedef logic signed [DATA_W-1:0] sample_t;
	typedef logic [DATA_W-1:0]        word_t;
	typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

	localparam op_t OP_ALPHA   = 2'd0;
	localparam op_t OP_PERIOD  = 2'd1;
	localparam op_t OP_RESTART = 2'd2;
	localparam op_t OP_NONE    = 2'd3;

	localparam cfg_idx_t REG_ALPHA = 2'd0;
	localparam cfg_idx_t REG_OMEGA = 2'd1;
	localparam cfg_idx_t REG_WRAP  = 2'd2;

	localparam logic [ALPHA_W-1:0] ALPHA_RST = 16'd6554;
	localparam word_t              OMEGA_RST = 32'd411775;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
		logic [DIV_W-1:0]  rem_init;
		logic [DIV_W-1:0]  den;
		logic [VAL_W-1:0]  dvd;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quo;
		logic [DIV_W-1:0] rem;
	} div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/flp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flp_if: channel interfaces of the first-order low-pass
// Sample input, filtered output and register write channels.
// ----------------------------------------------------------------------------
interface flp_in_if import flp_pkg::*; ();
	logic    valid;
	logic    ready;
	op_t     op;
	sample_t sample;
	word_t   sample_period;

	modport source(output valid, output op, output sample, output sample_period, input ready);
	modport sink(input valid, input op, input sample, input sample_period, output ready);
endinterface

interface flp_out_if import flp_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t filtered;

	modport source(output valid, output filtered, input ready);
	modport sink(input valid, input filtered, output ready);
endinterface

interface flp_cfg_if import flp_pkg::*; ();
	logic     valid;
	logic     ready;
	cfg_idx_t index;
	word_t    data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/flp_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flp_mul: shared registered multiplier
// Signed product of two operands, available in the cycle after they are set.
// ----------------------------------------------------------------------------
module flp_mul import flp_pkg::*; (
	input  logic                     clk,
	input  logic signed [MUL_W-1:0]  opa,
	input  logic signed [MUL_W-1:0]  opb,
	output logic signed [PROD_W-1:0] prod
);

	logic signed [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(opa) * PROD_W'(opb);
	end

	assign prod = prod_q;

endmodule
`default_nettype wire

// ===== rtl/flp_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flp_divider: shared shift-subtract divider
// One quotient bit per cycle; dividend bits enter the remainder MSB first.
// Serves both the alpha quotient and the floored modulo of the wrap.
// ----------------------------------------------------------------------------
module flp_divider import flp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  den_q;
	logic [VAL_W-1:0]  dvd_q;
	logic [QUO_W-1:0]  quo_q;
	logic [DIV_W-1:0]  trial;
	logic [DIV_W-1:0]  diff;
	logic              ge;

	assign trial = {rem_q[DIV_W-2:0], dvd_q[VAL_W-1]};
	assign ge    = trial >= den_q;
	assign diff  = trial - den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem_init;
			den_q <= req.den;
			dvd_q <= req.dvd;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff : trial;
			dvd_q <= {dvd_q[VAL_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q < den_q)
		else $error("divider remainder not below divisor");

	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q && req.steps != '0)
		else $error("divider started while busy or with no steps");

	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q))
		else $error("divider done without a finished run");

endmodule
`default_nettype wire

// ===== rtl/first_order_lowpass_with_wrap.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_order_lowpass_with_wrap: exponential smoothing of Q16.16 samples
// Sequencer around one registered multiplier and one shift-subtract divider.
// ----------------------------------------------------------------------------
// One sample at a time. A restart, an unused op or the first sample after
// reset or restart goes from idle straight to the done state, which raises
// its result valid once the output is free. A filter step with the register
// alpha passes the diff, mul and add states; a computed alpha first passes
// mula and alpha (16 divider steps for the Q0.16 quotient). With wrapping
// on, each of the two floored modulo passes adds wrapd or wrapy (35 divider
// steps, one bit per cycle). A new sample is taken while the previous
// result still waits on the output.
// ----------------------------------------------------------------------------
module first_order_lowpass_with_wrap import flp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	flp_cfg_if.sink   cfg,
	flp_in_if.sink    samples,
	flp_out_if.source results
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MULA  = 4'd1;
	localparam logic [3:0] S_ALPHA = 4'd2;
	localparam logic [3:0] S_DIFF  = 4'd3;
	localparam logic [3:0] S_WRAPD = 4'd4;
	localparam logic [3:0] S_MUL   = 4'd5;
	localparam logic [3:0] S_ADD   = 4'd6;
	localparam logic [3:0] S_WRAPY = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	logic [3:0]               state_q;
	logic [ALPHA_W-1:0]       alpha_q;
	word_t                    omega_q;
	logic [WRAP_W-1:0]        wrap_q;
	sample_t                  y_q;
	logic                     first_q;
	logic                     res_valid_q;
	sample_t                  x_q;
	logic [ALPHA_W-1:0]       a_q;
	logic signed [DIFF_W-1:0] d_q;
	logic                     neg_q;
	sample_t                  res_q;

	logic                     in_fire;
	logic                     wrap_on;
	logic signed [MUL_W-1:0]  opa;
	logic signed [MUL_W-1:0]  opb;
	logic signed [PROD_W-1:0] prod;
	logic [DIV_W-1:0]         m;
	logic signed [DIFF_W-1:0] d_full;
	logic signed [VAL_W-1:0]  wsgn;
	logic signed [VAL_W-1:0]  ysum;
	logic signed [VAL_W-1:0]  mod_v;
	logic [VAL_W-1:0]         mod_mag;
	word_t                    period2;
	word_t                    rem_lo;
	word_t                    adj;
	logic signed [VAL_W-1:0]  wres;
	div_req_t                 req;
	div_rsp_t                 rsp;

	assign cfg.ready     = 1'b1;
	assign samples.ready = state_q == S_IDLE;
	assign in_fire       = samples.valid && samples.ready;
	assign results.valid    = res_valid_q;
	assign results.filtered = res_q;

	assign wrap_on = wrap_q != '0;

	always_comb begin
		if (state_q == S_IDLE) begin
			opa = signed'(MUL_W'(omega_q));
			opb = signed'(MUL_W'(samples.sample_period));
		end else begin
			opa = signed'(MUL_W'(a_q));
			opb = MUL_W'(d_q);
		end
	end

	flp_mul u_mul (
		.clk  (clk),
		.opa  (opa),
		.opb  (opb),
		.prod (prod)
	);

	assign m       = prod[DIV_W+1:2];
	assign d_full  = DIFF_W'(x_q) - DIFF_W'(y_q);
	assign wsgn    = signed'(VAL_W'(wrap_q));
	assign ysum    = VAL_W'(y_q) + VAL_W'(prod >>> ALPHA_W);
	assign mod_v   = (state_q == S_DIFF) ? (VAL_W'(d_full) + wsgn) : (ysum + wsgn);
	assign mod_mag = mod_v[VAL_W-1] ? unsigned'(-mod_v) : unsigned'(mod_v);
	assign period2 = {wrap_q, 1'b0};
	assign rem_lo  = rsp.rem[DATA_W-1:0];
	assign adj     = (neg_q && rem_lo != '0) ? (period2 - rem_lo) : rem_lo;
	assign wres    = signed'(VAL_W'(adj)) - wsgn;

	always_comb begin
		req = '0;
		case (state_q)
			S_MULA: begin
				req.start    = 1'b1;
				req.steps    = STEP_W'(ALPHA_STEPS);
				req.rem_init = m;
				req.den      = m + (DIV_W'(1) << M_ONE_BIT);
			end
			S_DIFF, S_ADD: begin
				req.start    = wrap_on;
				req.steps    = STEP_W'(VAL_W);
				req.den      = DIV_W'(period2);
				req.dvd      = mod_mag;
			end
			default: begin
			end
		endcase
	end

	flp_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			alpha_q     <= ALPHA_RST;
			omega_q     <= OMEGA_RST;
			wrap_q      <= '0;
			y_q         <= '0;
			first_q     <= 1'b1;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					REG_ALPHA: alpha_q <= cfg.data[ALPHA_W-1:0];
					REG_OMEGA: omega_q <= cfg.data;
					REG_WRAP:  wrap_q  <= cfg.data[WRAP_W-1:0];
					default: begin
					end
				endcase
			end
			if (state_q == S_DONE && (!res_valid_q || results.ready)) begin
				res_valid_q <= 1'b1;
			end else if (results.valid && results.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						case (samples.op)
							OP_NONE: state_q <= S_DONE;
							OP_RESTART: begin
								y_q     <= '0;
								first_q <= 1'b1;
								state_q <= S_DONE;
							end
							default: begin
								if (first_q) begin
									y_q     <= samples.sample;
									first_q <= 1'b0;
									state_q <= S_DONE;
								end else if (samples.op == OP_PERIOD) begin
									state_q <= S_MULA;
								end else begin
									state_q <= S_DIFF;
								end
							end
						endcase
					end
				end
				S_MULA:  state_q <= S_ALPHA;
				S_ALPHA: if (rsp.done) state_q <= S_DIFF;
				S_DIFF:  state_q <= wrap_on ? S_WRAPD : S_MUL;
				S_WRAPD: if (rsp.done) state_q <= S_MUL;
				S_MUL:   state_q <= S_ADD;
				S_ADD: begin
					if (wrap_on) begin
						state_q <= S_WRAPY;
					end else begin
						y_q     <= ysum[DATA_W-1:0];
						state_q <= S_DONE;
					end
				end
				S_WRAPY: begin
					if (rsp.done) begin
						y_q     <= wres[DATA_W-1:0];
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!res_valid_q || results.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_q <= samples.sample;
			a_q <= alpha_q;
		end
		if (state_q == S_ALPHA && rsp.done) begin
			a_q <= rsp.quo;
		end
		if (state_q == S_DIFF) begin
			d_q   <= d_full;
			neg_q <= mod_v[VAL_W-1];
		end
		if (state_q == S_WRAPD && rsp.done) begin
			d_q <= wres[DIFF_W-1:0];
		end
		if (state_q == S_ADD) begin
			neg_q <= mod_v[VAL_W-1];
		end
		if (state_q == S_DONE && (!res_valid_q || results.ready)) begin
			res_q <= y_q;
		end
	end

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && samples.op == OP_RESTART |=> first_q && y_q == '0)
		else $error("restart did not clear the filter state");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result raised outside the done state");

	a_idle_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && (!res_valid_q || results.ready) |=> state_q == S_IDLE)
		else $error("sequencer did not return to idle after the result");

endmodule
`default_nettype wire
